/* src/gaussian_crossing_threshold_unit_macros.svh */
// Assertion macros shared by the crossing threshold RTL.
`ifndef GAUSSIAN_CROSSING_THRESHOLD_UNIT_MACROS_SVH
`define GAUSSIAN_CROSSING_THRESHOLD_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define GCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define GCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gct_pkg.sv */
// Shared types and constants for the Gaussian crossing threshold unit.
package gct_pkg;

    localparam int GCT_FRACTION_BITS = 8;
    localparam int GCT_COUNT_WIDTH   = 16;
    localparam int GCT_SUM_WIDTH     = 40;
    localparam int GCT_MOMENT_WIDTH  = 48;
    localparam int GCT_THRESH_WIDTH  = 41;

    typedef enum logic [1:0] {
        GCT_ST_FIRST  = 2'd0,
        GCT_ST_SECOND = 2'd1,
        GCT_ST_NONE   = 2'd2,
        GCT_ST_DEGEN  = 2'd3
    } gct_status_t;

    typedef struct packed {
        logic [GCT_COUNT_WIDTH-1:0]         count_a;
        logic [GCT_COUNT_WIDTH-1:0]         count_b;
        logic signed [GCT_SUM_WIDTH-1:0]    sum_a;
        logic signed [GCT_SUM_WIDTH-1:0]    sum_b;
        logic [GCT_MOMENT_WIDTH-1:0]        moment_a;
        logic [GCT_MOMENT_WIDTH-1:0]        moment_b;
    } gct_in_t;

    typedef struct packed {
        logic signed [GCT_THRESH_WIDTH-1:0] threshold_value;
        gct_status_t                        status;
    } gct_out_t;

endpackage

/* src/gct_pipe_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module gct_pipe_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg [NUM_W+1];
    logic [NUM_W-1:0]  work_reg  [NUM_W+1];
    logic [DEN_W-1:0]  rem_reg   [NUM_W+1];
    logic [DEN_W-1:0]  den_reg   [NUM_W+1];
    logic [SIDE_W-1:0] side_reg  [NUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg[0] <= num;
            rem_reg[0]  <= rem_init;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] work_next;

        always_comb
        begin
            shifted   = {rem_reg[i], work_reg[i][NUM_W-1]};
            diff      = {1'b0, shifted} - {2'b00, den_reg[i]};
            ge        = !diff[DEN_W+1];
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            work_next = {work_reg[i][NUM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[i+1] <= work_next;
                rem_reg[i+1]  <= rem_next;
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W];
    assign quo       = work_reg[NUM_W];
    assign side_out  = side_reg[NUM_W];

endmodule

/* src/gct_pipe_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
module gct_pipe_sqrt #(
    parameter int RW     = 28,
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   num,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg [RW+1];
    logic [2*RW-1:0]   num_reg   [RW+1];
    logic [RW+1:0]     rem_reg   [RW+1];
    logic [RW-1:0]     root_reg  [RW+1];
    logic [SIDE_W-1:0] side_reg  [RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= num;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RW+1:0] r2;
        logic [RW+2:0] trial;
        logic          ge;

        always_comb
        begin
            r2    = {rem_reg[i][RW-1:0], num_reg[i][2*RW-1:2*RW-2]};
            trial = {1'b0, r2} - {1'b0, root_reg[i], 2'b01};
            ge    = !trial[RW+2];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i+1]  <= {num_reg[i][2*RW-3:0], 2'b00};
                rem_reg[i+1]  <= ge ? trial[RW+1:0] : r2;
                root_reg[i+1] <= {root_reg[i][RW-2:0], ge};
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = root_reg[RW];
    assign side_out  = side_reg[RW];

endmodule

/* src/gaussian_crossing_threshold_unit.sv */
// Gaussian crossing threshold unit: top level pipeline.
//
// Input channel (item_valid / item_stall / item): one beat carries both classes'
// counts, integer sums and Q(48-F).F second moments.
// Output channel (result_valid / result_stall / result): one beat per input beat,
// in order, with the crossing point in Q(40-F).F and a status code.
// Throughput: one beat per cycle while item_stall is low. An accepted input beat
// passes the class-mean dividers, registers p1 to p3, the square root, registers
// p5 to p7, the deviation-weighted split divider and the output register before
// result_valid; the two dividers and the square root resolve one bit per stage.
// Reset clears every valid bit, including those of the output register and the
// skid slot; no results are pending afterwards.
// When result_stall holds a valid beat, the next finished beat lands in a skid
// slot; item_stall then rises and the whole pipeline freezes until the held beat
// is taken. Nothing is dropped or duplicated.
// Degenerate inputs (zero count, zero variance, equal variances) give -1.0 with
// status 3; no crossing strictly between the means gives -1.0 with status 2.
`include "gaussian_crossing_threshold_unit_macros.svh"

module gaussian_crossing_threshold_unit
    import gct_pkg::*;
#(
    parameter int FRACTION_BITS = GCT_FRACTION_BITS
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  gct_in_t  item,
    output logic     result_valid,
    input  logic     result_stall,
    output gct_out_t result
);

    localparam int MOM_W = GCT_MOMENT_WIDTH;
    localparam int TW    = GCT_THRESH_WIDTH;
    localparam int MW    = GCT_SUM_WIDTH + FRACTION_BITS;
    localparam int DW    = MW + 1;
    localparam int RW    = (MOM_W + FRACTION_BITS + 1) / 2;
    localparam int DL    = (DW + 1) / 2;
    localparam int DH    = DW - DL;
    localparam int PW    = DW + RW;
    localparam int XW    = MW + 2;
    localparam int EW    = ((XW > TW) ? XW : TW) + 1;

    localparam logic [MOM_W-1:0] ONE_MOM  = MOM_W'(1) << FRACTION_BITS;
    localparam logic [RW-1:0]    ONE_DEV  = RW'(1) << FRACTION_BITS;
    localparam logic [TW-1:0]    NONE_VAL =
        {{(TW-FRACTION_BITS){1'b1}}, {FRACTION_BITS{1'b0}}};
    localparam logic [EW-1:0]    HI_E = {{(EW-TW+1){1'b0}}, {(TW-1){1'b1}}};
    localparam logic [EW-1:0]    LO_E = {{(EW-TW+1){1'b1}}, {(TW-1){1'b0}}};

    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [MOM_W-1:0] mom;
    } div_side_t;

    typedef struct packed {
        logic signed [MW-1:0] mean;
        logic [MOM_W-1:0]     var_eff;
        logic                 neg;
        logic                 degen;
    } sqrt_side_t;

    typedef struct packed {
        logic signed [MW-1:0] m1;
        logic                 up;
        logic                 degen;
    } fin_side_t;

    logic en;

    logic [GCT_COUNT_WIDTH-1:0] cnt [2];
    logic [GCT_SUM_WIDTH-1:0]   sum [2];
    logic [MOM_W-1:0]           mom [2];

    logic [1:0] div_valid;
    logic [1:0] sqrt_valid;

    logic                 p1_valid_reg;
    logic signed [MW-1:0] p1_mean_reg [2];
    logic [31:0]          p1_mag_reg  [2];
    logic                 p1_big_reg  [2];
    logic                 p1_zero_reg [2];
    logic [MOM_W-1:0]     p1_mom_reg  [2];

    logic                 p2_valid_reg;
    logic signed [MW-1:0] p2_mean_reg [2];
    logic [63:0]          p2_sq_reg   [2];
    logic                 p2_big_reg  [2];
    logic                 p2_zero_reg [2];
    logic [MOM_W-1:0]     p2_mom_reg  [2];

    logic                 p3_valid_reg;
    logic signed [MW-1:0] p3_mean_reg  [2];
    logic [MOM_W-1:0]     p3_var_reg   [2];
    logic                 p3_neg_reg   [2];
    logic                 p3_degen_reg [2];

    logic signed [MW-1:0] mean_s  [2];
    logic [MOM_W-1:0]     var_s   [2];
    logic                 degen_s [2];
    logic [RW-1:0]        dev_s   [2];

    assign cnt[0] = item.count_a;
    assign cnt[1] = item.count_b;
    assign sum[0] = item.sum_a;
    assign sum[1] = item.sum_b;
    assign mom[0] = item.moment_a;
    assign mom[1] = item.moment_b;

    for (genvar c = 0; c < 2; c++)
    begin : g_class
        logic [GCT_SUM_WIDTH-1:0] sum_mag;
        div_side_t                side_in;
        div_side_t                side_out;
        logic [MW-1:0]            quo;
        logic [MW+31:0]           quo_ext;
        logic [63:0]              sq_shift;
        logic                     neg_next;
        logic [MOM_W-1:0]         var_diff;
        logic [2*RW-1:0]          sq_num;
        sqrt_side_t               sq_side_in;
        sqrt_side_t               sq_side_out;
        logic [RW-1:0]            root;

        assign sum_mag       = sum[c][GCT_SUM_WIDTH-1] ? -sum[c] : sum[c];
        assign side_in.neg   = sum[c][GCT_SUM_WIDTH-1];
        assign side_in.zero  = (cnt[c] == '0);
        assign side_in.mom   = mom[c];

        gct_pipe_div #(
            .NUM_W  (MW),
            .DEN_W  (GCT_COUNT_WIDTH),
            .SIDE_W ($bits(div_side_t))
        ) u_mean_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (item_valid),
            .num       ({sum_mag, {FRACTION_BITS{1'b0}}}),
            .rem_init  ('0),
            .den       (cnt[c]),
            .side_in   (side_in),
            .out_valid (div_valid[c]),
            .quo       (quo),
            .side_out  (side_out)
        );

        assign quo_ext = {32'd0, quo};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_mean_reg[c] <= side_out.neg ? $signed(-quo) : $signed(quo);
                p1_mag_reg[c]  <= quo_ext[31:0];
                p1_big_reg[c]  <= |quo_ext[MW+31:32];
                p1_zero_reg[c] <= side_out.zero;
                p1_mom_reg[c]  <= side_out.mom;

                p2_mean_reg[c] <= p1_mean_reg[c];
                p2_sq_reg[c]   <= p1_mag_reg[c] * p1_mag_reg[c];
                p2_big_reg[c]  <= p1_big_reg[c];
                p2_zero_reg[c] <= p1_zero_reg[c];
                p2_mom_reg[c]  <= p1_mom_reg[c];

                p3_mean_reg[c]  <= p2_mean_reg[c];
                p3_var_reg[c]   <= neg_next ? ONE_MOM : var_diff;
                p3_neg_reg[c]   <= neg_next;
                p3_degen_reg[c] <= p2_zero_reg[c] || (!neg_next && var_diff == '0);
            end
        end

        // Square of the mean above the moment: variance counts as 1.0.
        always_comb
        begin
            sq_shift = p2_sq_reg[c] >> FRACTION_BITS;
            neg_next = p2_big_reg[c] || (sq_shift > 64'(p2_mom_reg[c]));
            var_diff = p2_mom_reg[c] - sq_shift[MOM_W-1:0];
        end

        assign sq_num             = (2*RW)'({p3_var_reg[c], {FRACTION_BITS{1'b0}}});
        assign sq_side_in.mean    = p3_mean_reg[c];
        assign sq_side_in.var_eff = p3_var_reg[c];
        assign sq_side_in.neg     = p3_neg_reg[c];
        assign sq_side_in.degen   = p3_degen_reg[c];

        gct_pipe_sqrt #(
            .RW     (RW),
            .SIDE_W ($bits(sqrt_side_t))
        ) u_dev_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (p3_valid_reg),
            .num       (sq_num),
            .side_in   (sq_side_in),
            .out_valid (sqrt_valid[c]),
            .root      (root),
            .side_out  (sq_side_out)
        );

        assign mean_s[c]  = sq_side_out.mean;
        assign var_s[c]   = sq_side_out.var_eff;
        assign degen_s[c] = sq_side_out.degen;
        assign dev_s[c]   = sq_side_out.neg ? ONE_DEV : root;
    end

    // Merge classes: distance between means and weight split.
    logic                 up_next;
    logic signed [DW-1:0] m1x;
    logic signed [DW-1:0] m2x;
    logic [DW-1:0]        d_next;

    logic                 p5_valid_reg;
    logic [DW-1:0]        p5_d_reg;
    logic [RW-1:0]        p5_s1_reg;
    logic [RW:0]          p5_den_reg;
    logic signed [MW-1:0] p5_m1_reg;
    logic                 p5_up_reg;
    logic                 p5_degen_reg;

    logic                 p6_valid_reg;
    logic [DL+RW-1:0]     p6_plo_reg;
    logic [DH+RW-1:0]     p6_phi_reg;
    logic [RW:0]          p6_den_reg;
    logic signed [MW-1:0] p6_m1_reg;
    logic                 p6_up_reg;
    logic                 p6_degen_reg;

    logic                 p7_valid_reg;
    logic [PW-1:0]        p7_prod_reg;
    logic [RW:0]          p7_den_reg;
    fin_side_t            p7_side_reg;

    always_comb
    begin
        up_next = (mean_s[1] >= mean_s[0]);
        m1x     = {mean_s[0][MW-1], mean_s[0]};
        m2x     = {mean_s[1][MW-1], mean_s[1]};
        d_next  = up_next ? DW'(m2x - m1x) : DW'(m1x - m2x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= div_valid[0] & div_valid[1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p5_valid_reg <= sqrt_valid[0] & sqrt_valid[1];
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_d_reg     <= d_next;
            p5_s1_reg    <= dev_s[0];
            p5_den_reg   <= {1'b0, dev_s[0]} + {1'b0, dev_s[1]};
            p5_m1_reg    <= mean_s[0];
            p5_up_reg    <= up_next;
            p5_degen_reg <= degen_s[0] || degen_s[1] || (var_s[0] == var_s[1]);

            p6_plo_reg   <= p5_d_reg[DL-1:0] * p5_s1_reg;
            p6_phi_reg   <= p5_d_reg[DW-1:DL] * p5_s1_reg;
            p6_den_reg   <= p5_den_reg;
            p6_m1_reg    <= p5_m1_reg;
            p6_up_reg    <= p5_up_reg;
            p6_degen_reg <= p5_degen_reg;

            p7_prod_reg       <= PW'(p6_plo_reg) + (PW'(p6_phi_reg) << DL);
            p7_den_reg        <= p6_den_reg;
            p7_side_reg.m1    <= p6_m1_reg;
            p7_side_reg.up    <= p6_up_reg;
            p7_side_reg.degen <= p6_degen_reg;
        end
    end

    // Quotient fits DW bits, so the top of the product is already below den.
    logic          tail_valid;
    logic [DW-1:0] fin_q;
    fin_side_t     fin_side;

    gct_pipe_div #(
        .NUM_W  (DW),
        .DEN_W  (RW + 1),
        .SIDE_W ($bits(fin_side_t))
    ) u_split_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p7_valid_reg),
        .num       (p7_prod_reg[DW-1:0]),
        .rem_init  ({1'b0, p7_prod_reg[PW-1:DW]}),
        .den       (p7_den_reg),
        .side_in   (p7_side_reg),
        .out_valid (tail_valid),
        .quo       (fin_q),
        .side_out  (fin_side)
    );

    logic [XW-1:0] m1e;
    logic [XW-1:0] qe;
    logic [XW-1:0] x_sum;
    logic [EW-1:0] xe;
    logic [TW-1:0] x_sat;
    gct_out_t      tail;

    always_comb
    begin
        m1e   = {{2{fin_side.m1[MW-1]}}, fin_side.m1};
        qe    = {1'b0, fin_q};
        x_sum = fin_side.up ? (m1e + qe) : (m1e - qe);
        xe    = {{(EW-XW){x_sum[XW-1]}}, x_sum};
        priority if ($signed(xe) > $signed(HI_E))
        begin
            x_sat = HI_E[TW-1:0];
        end
        else if ($signed(xe) < $signed(LO_E))
        begin
            x_sat = LO_E[TW-1:0];
        end
        else
        begin
            x_sat = xe[TW-1:0];
        end

        priority if (fin_side.degen)
        begin
            tail.threshold_value = NONE_VAL;
            tail.status          = GCT_ST_DEGEN;
        end
        else if (fin_q == '0)
        begin
            tail.threshold_value = NONE_VAL;
            tail.status          = GCT_ST_NONE;
        end
        else
        begin
            tail.threshold_value = x_sat;
            tail.status          = fin_side.up ? GCT_ST_FIRST : GCT_ST_SECOND;
        end
    end

    // Output register plus skid slot.
    logic     result_valid_reg;
    logic     result_valid_next;
    logic     skid_full_reg;
    logic     skid_full_next;
    logic     load_from_skid;
    logic     load_from_tail;
    logic     load_skid;
    gct_out_t result_reg;
    gct_out_t skid_reg;

    assign en           = !skid_full_reg;
    assign item_stall   = skid_full_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        load_from_skid    = skid_full_reg && !result_stall;
        load_from_tail    = !skid_full_reg && (!result_valid_reg || !result_stall);
        load_skid         = !skid_full_reg && result_valid_reg && result_stall && tail_valid;
        result_valid_next = result_valid_reg;
        skid_full_next    = skid_full_reg;
        priority if (load_from_skid)
        begin
            skid_full_next = 1'b0;
        end
        else if (load_from_tail)
        begin
            result_valid_next = tail_valid;
        end
        else if (load_skid)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_full_reg    <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_full_reg    <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            result_reg <= skid_reg;
        end
        else if (load_from_tail)
        begin
            result_reg <= tail;
        end
        if (load_skid)
        begin
            skid_reg <= tail;
        end
    end

    `GCT_ASSERT_NOW(a_skid_needs_out, skid_full_reg, result_valid_reg,
        "skid beat without held beat")
    `GCT_ASSERT_NEXT(a_skid_drains, skid_full_reg && !result_stall,
        !skid_full_reg && result_valid_reg, "skid beat not moved out")
    `GCT_ASSERT_NOW(a_none_value, result_valid_reg &&
        (result_reg.status == GCT_ST_NONE || result_reg.status == GCT_ST_DEGEN),
        result_reg.threshold_value == NONE_VAL, "no-crossing beat without -1.0")
    `GCT_ASSERT_NEXT(a_tail_frozen, skid_full_reg && result_stall,
        $stable(tail_valid) && $stable(fin_q), "pipeline moved while skid full")

endmodule
